// ----- hdl/rgcl_pkg.sv -----
// Package for the rectilinear grid cell locator: sizes, codes and the
// scan control bundle shared by the top level and the axis scanner.
// No dependencies.
package rgcl_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;
   localparam int COORD_BITS = 32;

   localparam int NUM_CELLS  = MAX_COLS * MAX_ROWS;
   localparam int X_DEPTH    = MAX_COLS + 1;
   localparam int Y_DEPTH    = MAX_ROWS + 1;
   localparam int X_AW       = $clog2(X_DEPTH);
   localparam int Y_AW       = $clog2(Y_DEPTH);
   localparam int CELL_AW    = $clog2(NUM_CELLS);
   localparam int AXIS_MAX   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   // holds every count and search index 0..AXIS_MAX+1
   localparam int AX_W       = $clog2(AXIS_MAX + 2);

   localparam int CNT_W      = 7;
   localparam int TOL_W      = 16;
   localparam int OFS_W      = 32;
   localparam int COL_W      = 6;
   localparam int ROW_W      = 6;
   localparam int NUM_W      = 12;
   localparam int TIDX_W     = 12;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd2;

   localparam logic [1:0] FUNC_WR_X    = 2'd0;
   localparam logic [1:0] FUNC_WR_Y    = 2'd1;
   localparam logic [1:0] FUNC_WR_OFS  = 2'd2;
   localparam logic [1:0] FUNC_LOCATE  = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic            start;
      logic            rd_vld;
      logic [AX_W-1:0] rd_idx;
   } scan_ctl_type;

endpackage

// ----- hdl/rgcl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module rgcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/rgcl_axis.sv -----
// Boundary scanner for one axis: consumes boundary beats read from memory,
// records the first boundary not below the point and derives the cell index.
// Depends on rgcl_pkg.
module rgcl_axis import rgcl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  scan_ctl_type    ctl,
   input  coord_type       rd_data,
   input  coord_type       point,
   input  logic            dir_pos,
   input  logic [AX_W-1:0] count,
   input  logic [TOL_W-1:0] tolerance,
   output logic [AX_W-1:0] cell_idx,
   output coord_type       bnd_last
);

   logic            found_ff, found_in;
   logic            eq_ff, eq_in;
   logic [AX_W-1:0] k_ff, k_in;
   coord_type       bnd_last_ff, bnd_last_in;

   coord_type       diff;
   logic            near;
   logic            below;
   logic [AX_W-1:0] k_fin;
   logic [AX_W-1:0] k_m1;
   logic [AX_W-1:0] lim;

   always_comb begin
      diff  = (rd_data > point) ? (rd_data - point) : (point - rd_data);
      near  = diff < {{(COORD_BITS-TOL_W){1'b0}}, tolerance};
      below = (rd_data < point) && !near;

      found_in    = found_ff;
      eq_in       = eq_ff;
      k_in        = k_ff;
      bnd_last_in = bnd_last_ff;
      if (ctl.start) begin
         found_in = 1'b0;
      end else if (ctl.rd_vld) begin
         // first boundary that is not clearly below the point
         if ((ctl.rd_idx <= count) && !found_ff && !below) begin
            found_in = 1'b1;
            k_in     = ctl.rd_idx;
            eq_in    = near;
         end
         if (ctl.rd_idx == count) begin
            bnd_last_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      eq_ff       <= eq_in;
      k_ff        <= k_in;
      bnd_last_ff <= bnd_last_in;
   end

   // on a boundary, a positive direction moves to the upper cell
   always_comb begin
      if (!found_ff) begin
         k_fin = count + AX_W'(1);
      end else if (eq_ff && dir_pos) begin
         k_fin = k_ff + AX_W'(1);
      end else begin
         k_fin = k_ff;
      end
      k_m1 = (k_fin == '0) ? '0 : (k_fin - AX_W'(1));
      lim  = count - AX_W'(1);
      cell_idx = (k_m1 > lim) ? lim : k_m1;
   end

   assign bnd_last = bnd_last_ff;

endmodule

// ----- hdl/rectilinear_grid_cell_locator_unit.sv -----
// Rectilinear grid cell locator. Write beats (tuser 0..2) load x boundaries,
// y boundaries and per-cell region offsets. A locate beat scans both
// boundary lists in parallel, one memory read per axis per cycle, over
// indices 0..max(columns,rows), then reads the cell's lower and upper edges and its offset;
// the scan is linear, through the single read port of each boundary memory,
// and no new request is taken until the locate has loaded its response.
// Boundary and offset memories are undefined until written. Depends on
// rgcl_pkg, rgcl_ram, rgcl_axis.
module rectilinear_grid_cell_locator_unit import rgcl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // config write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [11:0] table_index, [43:12] table_value, [75:44] point_x,
   // [107:76] point_y, [108] dir_x_positive, [109] dir_y_positive,
   // [141:110] region_base, [143:142] zero
   input  logic [143:0]          req_tdata,
   // [1:0] func
   input  logic [1:0]            req_tuser,
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] cell_col, [11:6] cell_row, [23:12] cell_number, [55:24] center_x,
   // [87:56] center_y, [119:88] region_out, [120] out_of_range, [127:121] zero
   output logic [127:0]          rsp_tdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_FIND  = 3'd3;
   localparam logic [2:0] ST_EDGE0 = 3'd4;
   localparam logic [2:0] ST_EDGE1 = 3'd5;
   localparam logic [2:0] ST_EDGE2 = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // request fields
   logic [1:0]        f_func;
   logic [TIDX_W-1:0] f_tidx;
   logic [31:0]       f_tval;
   coord_type         f_px, f_py;
   logic              f_dxp, f_dyp;
   logic [31:0]       f_base;

   assign f_func = req_tuser;
   assign f_tidx = req_tdata[11:0];
   assign f_tval = req_tdata[43:12];
   assign f_px   = COORD_BITS'(req_tdata[75:44]);
   assign f_py   = COORD_BITS'(req_tdata[107:76]);
   assign f_dxp  = req_tdata[108];
   assign f_dyp  = req_tdata[109];
   assign f_base = req_tdata[141:110];

   // config registers
   logic [CNT_W-1:0] cells_x_ff, cells_y_ff;
   logic [TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CNT_W'(1);
         cells_y_ff <= CNT_W'(1);
         tol_ff     <= TOL_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS_X:   cells_x_ff <= csr_wdata[CNT_W-1:0];
            CSR_CELLS_Y:   cells_y_ff <= csr_wdata[CNT_W-1:0];
            CSR_TOLERANCE: tol_ff     <= csr_wdata[TOL_W-1:0];
            default:       ;
         endcase
      end
   end

   logic [AX_W-1:0] nx, ny, nmax;

   always_comb begin
      if (cells_x_ff == '0) begin
         nx = AX_W'(1);
      end else if (cells_x_ff > CNT_W'(MAX_COLS)) begin
         nx = AX_W'(MAX_COLS);
      end else begin
         nx = AX_W'(cells_x_ff);
      end
      if (cells_y_ff == '0) begin
         ny = AX_W'(1);
      end else if (cells_y_ff > CNT_W'(MAX_ROWS)) begin
         ny = AX_W'(MAX_ROWS);
      end else begin
         ny = AX_W'(cells_y_ff);
      end
      nmax = (nx > ny) ? nx : ny;
   end

   // control and payload registers
   logic [2:0]        state_ff, state_in;
   logic [AX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AX_W-1:0]   rd_idx_ff, rd_idx_in;
   coord_type         px_ff, px_in, py_ff, py_in;
   logic              dxp_ff, dxp_in, dyp_ff, dyp_in;
   logic [31:0]       base_ff, base_in;
   logic [AX_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [CELL_AW-1:0] cell_ff, cell_in;
   coord_type         xlo_ff, xlo_in, ylo_ff, ylo_in;
   coord_type         xhi_ff, xhi_in, yhi_ff, yhi_in;
   logic [OFS_W-1:0]  ofs_ff, ofs_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [127:0]      rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              scan_start;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_start = req_fire && (f_func == FUNC_LOCATE);

   // memories
   logic              xm_we, ym_we, om_we;
   logic [X_AW-1:0]   xm_raddr;
   logic [Y_AW-1:0]   ym_raddr;
   logic [CELL_AW-1:0] om_raddr;
   coord_type         xm_rdata, ym_rdata;
   logic [OFS_W-1:0]  om_rdata;

   assign xm_we = req_fire && (f_func == FUNC_WR_X) && (f_tidx <= TIDX_W'(MAX_COLS));
   assign ym_we = req_fire && (f_func == FUNC_WR_Y) && (f_tidx <= TIDX_W'(MAX_ROWS));
   assign om_we = req_fire && (f_func == FUNC_WR_OFS)
                  && ({1'b0, f_tidx} < (TIDX_W+1)'(NUM_CELLS));

   rgcl_ram #(.WIDTH(COORD_BITS), .DEPTH(X_DEPTH)) u_xmem (
      .clock (clock),
      .we    (xm_we),
      .waddr (X_AW'(f_tidx)),
      .wdata (COORD_BITS'(f_tval)),
      .raddr (xm_raddr),
      .rdata (xm_rdata)
   );

   rgcl_ram #(.WIDTH(COORD_BITS), .DEPTH(Y_DEPTH)) u_ymem (
      .clock (clock),
      .we    (ym_we),
      .waddr (Y_AW'(f_tidx)),
      .wdata (COORD_BITS'(f_tval)),
      .raddr (ym_raddr),
      .rdata (ym_rdata)
   );

   rgcl_ram #(.WIDTH(OFS_W), .DEPTH(NUM_CELLS)) u_omem (
      .clock (clock),
      .we    (om_we),
      .waddr (CELL_AW'(f_tidx)),
      .wdata (f_tval),
      .raddr (om_raddr),
      .rdata (om_rdata)
   );

   // axis scanners
   scan_ctl_type    scan_ctl;
   logic [AX_W-1:0] x_cell, y_cell;
   coord_type       x_last, y_last;

   assign scan_ctl.start  = scan_start;
   assign scan_ctl.rd_vld = rd_vld_ff;
   assign scan_ctl.rd_idx = rd_idx_ff;

   rgcl_axis u_xaxis (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .rd_data   (xm_rdata),
      .point     (px_ff),
      .dir_pos   (dxp_ff),
      .count     (nx),
      .tolerance (tol_ff),
      .cell_idx  (x_cell),
      .bnd_last  (x_last)
   );

   rgcl_axis u_yaxis (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .rd_data   (ym_rdata),
      .point     (py_ff),
      .dir_pos   (dyp_ff),
      .count     (ny),
      .tolerance (tol_ff),
      .cell_idx  (y_cell),
      .bnd_last  (y_last)
   );

   // result arithmetic
   logic [COORD_BITS:0] sum_x, sum_y, lim_x, lim_y;
   logic [32:0]         reg_sum;
   logic [31:0]         region;
   coord_type           cen_x, cen_y;
   logic                oor;
   logic [AX_W+AX_W-1:0] prod;

   always_comb begin
      sum_x   = {1'b0, xlo_ff} + {1'b0, xhi_ff};
      sum_y   = {1'b0, ylo_ff} + {1'b0, yhi_ff};
      cen_x   = sum_x[COORD_BITS:1];
      cen_y   = sum_y[COORD_BITS:1];
      lim_x   = {1'b0, x_last} + (COORD_BITS+1)'(tol_ff);
      lim_y   = {1'b0, y_last} + (COORD_BITS+1)'(tol_ff);
      oor     = ({1'b0, px_ff} > lim_x) || ({1'b0, py_ff} > lim_y);
      reg_sum = {1'b0, base_ff} + {1'b0, ofs_ff};
      region  = reg_sum[32] ? 32'hFFFF_FFFF : reg_sum[31:0];
      prod    = row_ff * nx + {{AX_W{1'b0}}, col_ff};
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      dxp_in      = dxp_ff;
      dyp_in      = dyp_ff;
      base_in     = base_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cell_in     = cell_ff;
      xlo_in      = xlo_ff;
      ylo_in      = ylo_ff;
      xhi_in      = xhi_ff;
      yhi_in      = yhi_ff;
      ofs_in      = ofs_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      xm_raddr    = '0;
      ym_raddr    = '0;
      om_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (scan_start) begin
               px_in       = f_px;
               py_in       = f_py;
               dxp_in      = f_dxp;
               dyp_in      = f_dyp;
               base_in     = f_base;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            xm_raddr  = X_AW'(scan_idx_ff);
            ym_raddr  = Y_AW'(scan_idx_ff);
            rd_vld_in = 1'b1;
            rd_idx_in = scan_idx_ff;
            if (scan_idx_ff == nmax) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + AX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIND;
         end
         ST_FIND: begin
            col_in   = x_cell;
            row_in   = y_cell;
            state_in = ST_EDGE0;
         end
         ST_EDGE0: begin
            xm_raddr = X_AW'(col_ff);
            ym_raddr = Y_AW'(row_ff);
            cell_in  = CELL_AW'(prod);
            state_in = ST_EDGE1;
         end
         ST_EDGE1: begin
            xm_raddr = X_AW'(col_ff + AX_W'(1));
            ym_raddr = Y_AW'(row_ff + AX_W'(1));
            om_raddr = cell_ff;
            xlo_in   = xm_rdata;
            ylo_in   = ym_rdata;
            state_in = ST_EDGE2;
         end
         ST_EDGE2: begin
            xhi_in   = xm_rdata;
            yhi_in   = ym_rdata;
            ofs_in   = om_rdata;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {7'd0, oor, region, 32'(cen_y), 32'(cen_x),
                              NUM_W'(cell_ff), ROW_W'(row_ff), COL_W'(col_ff)};
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dxp_ff      <= dxp_in;
      dyp_ff      <= dyp_in;
      base_ff     <= base_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      cell_ff     <= cell_in;
      xlo_ff      <= xlo_in;
      ylo_ff      <= ylo_in;
      xhi_ff      <= xhi_in;
      yhi_ff      <= yhi_in;
      ofs_ff      <= ofs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= nmax))
      else $error("scan index ran past the last boundary");

   a_locate_starts_scan: assert property (@(posedge clock) disable iff (reset)
      scan_start |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("locate beat did not start a scan");

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE0) |-> (col_ff < nx) && (row_ff < ny))
      else $error("located cell outside the grid");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response loaded outside the output state");

endmodule
